// ===== rtl/bbs_pkg.sv =====
// Shared types and constants for the backward search counter.
// Used by bbs_ctrl, bbs_datapath and bwt_backward_search_counter.
package bbs_pkg;

  localparam int unsigned SYM_W   = 3;
  localparam int unsigned MATCH_W = 13;

  typedef struct packed {
    logic load_en;
    logic pat_start;
    logic pat_exec;
    logic fin_step;
  } bbs_cmd_t;

  typedef struct packed {
    logic last_q;
    logic fin_done;
    logic out_free;
  } bbs_sts_t;

endpackage

// ===== rtl/bbs_ctrl.sv =====
// Controller for the backward search counter: accepts words and sequences
// load, search and prefix-sum passes. Depends on bbs_pkg.
module bbs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  logic             last_i,
  input  bbs_pkg::bbs_sts_t sts_i,
  output bbs_pkg::bbs_cmd_t cmd_o
);
  import bbs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SRCH = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i) begin
            cmd_o.pat_start = 1'b1;
            state_d         = ST_SRCH;
          end else begin
            cmd_o.load_en = 1'b1;
            if (last_i) begin
              state_d = ST_FIN;
            end
          end
        end
      end
      ST_SRCH: begin
        if (!sts_i.last_q || sts_i.out_free) begin
          cmd_o.pat_exec = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_FIN: begin
        cmd_o.fin_step = 1'b1;
        if (sts_i.fin_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && !sts_i.fin_done |=> state_q == ST_FIN)
    else $error("prefix pass left early");

  a_srch_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SRCH && (!sts_i.last_q || sts_i.out_free) |=> state_q == ST_IDLE)
    else $error("search step did not retire");

  a_pat_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_i |=> state_q == ST_SRCH)
    else $error("pattern word did not start a search step");

endmodule

// ===== rtl/bbs_datapath.sv =====
// Datapath for the backward search counter: occurrence memory, running counts,
// first positions, match range and result register. Depends on bbs_pkg.
module bbs_datapath #(
  parameter int unsigned MAX_LEN       = 4096,
  parameter int unsigned ALPHABET_SIZE = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bbs_pkg::SYM_W-1:0]   symbol_i,
  input  logic                        last_i,
  input  bbs_pkg::bbs_cmd_t           cmd_i,
  output bbs_pkg::bbs_sts_t           sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bbs_pkg::MATCH_W-1:0] match_count_o,
  output logic                        truncated_o
);
  import bbs_pkg::*;

  localparam int unsigned A         = ALPHABET_SIZE;
  localparam int unsigned MEM_DEPTH = MAX_LEN + 1;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned CW        = AW;
  localparam int unsigned RW        = CW + 1;
  localparam int unsigned SW        = (A > 1) ? $clog2(A) : 1;

  logic [A-1:0][CW-1:0] occ_mem [MEM_DEPTH];
  logic [A-1:0][CW-1:0] rd_top_q, rd_end_q, wr_row;

  logic [CW-1:0] counts_q [A];
  logic [CW-1:0] first_q  [A];
  logic [CW-1:0] len_q, sum_q;
  logic [RW-1:0] top_q, end_q, top_eff, end_eff;
  logic          active_q, ovf_q;
  logic [SYM_W-1:0] sym_q;
  logic          last_q, zt_q, ze_q;
  logic [SW-1:0] fin_idx_q, sym_idx;
  logic          out_valid_q, out_trunc_q;
  logic [MATCH_W-1:0] out_count_q;

  logic          in_sym_ok, full, wr_en, sym_ok_q, guard, push, out_free;
  logic [CW-1:0] occ_t, occ_e;
  logic [RW-1:0] nt, ne, new_top, new_end, cnt;

  assign in_sym_ok = int'(symbol_i) < A;
  assign full      = (len_q == CW'(MAX_LEN));
  assign wr_en     = cmd_i.load_en && in_sym_ok && !full;

  always_comb begin
    for (int c = 0; c < A; c++) begin
      wr_row[c] = counts_q[c] + CW'(int'(symbol_i) == c);
    end
  end

  assign top_eff = active_q ? top_q : '0;
  assign end_eff = active_q ? end_q : RW'(len_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      occ_mem[len_q + 1'b1] <= wr_row;
    end
    if (cmd_i.pat_start) begin
      rd_top_q <= occ_mem[top_eff[AW-1:0]];
      rd_end_q <= occ_mem[end_eff[AW-1:0]];
    end
  end

  assign sym_idx  = SW'(sym_q);
  assign sym_ok_q = int'(sym_q) < A;
  assign guard    = (top_q < end_q) && (end_q <= RW'(MAX_LEN));
  assign occ_t    = zt_q ? '0 : rd_top_q[sym_idx];
  assign occ_e    = ze_q ? '0 : rd_end_q[sym_idx];
  assign nt       = RW'(first_q[sym_idx]) + RW'(occ_t);
  assign ne       = RW'(first_q[sym_idx]) + RW'(occ_e);

  always_comb begin
    priority if (!sym_ok_q) begin
      new_top = '0;
      new_end = '0;
    end else if (guard) begin
      new_top = nt;
      new_end = ne;
    end else begin
      new_top = top_q;
      new_end = end_q;
    end
  end

  assign cnt      = (new_top < new_end) ? (new_end - new_top) : '0;
  assign out_free = !out_valid_q || out_ready_i;
  assign push     = cmd_i.pat_exec && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < A; c++) begin
        counts_q[c] <= '0;
        first_q[c]  <= '0;
      end
      len_q       <= '0;
      top_q       <= '0;
      end_q       <= '0;
      active_q    <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        for (int c = 0; c < A; c++) begin
          counts_q[c] <= wr_row[c];
        end
        len_q <= len_q + 1'b1;
      end
      if (cmd_i.load_en && in_sym_ok && full) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.fin_step) begin
        first_q[fin_idx_q] <= sum_q;
      end
      if (cmd_i.pat_start) begin
        top_q    <= top_eff;
        end_q    <= end_eff;
        active_q <= 1'b1;
      end
      if (cmd_i.pat_exec) begin
        top_q <= new_top;
        end_q <= new_end;
        if (last_q) begin
          active_q <= 1'b0;
        end
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en && last_i) begin
      fin_idx_q <= '0;
      sum_q     <= '0;
    end else if (cmd_i.fin_step) begin
      fin_idx_q <= fin_idx_q + 1'b1;
      sum_q     <= sum_q + counts_q[fin_idx_q];
    end
    if (cmd_i.pat_start) begin
      sym_q  <= symbol_i;
      last_q <= last_i;
      zt_q   <= (top_eff == '0);
      ze_q   <= (end_eff == '0);
    end
    if (push) begin
      out_count_q <= MATCH_W'(cnt);
      out_trunc_q <= ovf_q;
    end
  end

  assign sts_o.last_q   = last_q;
  assign sts_o.fin_done = (fin_idx_q == SW'(A - 1));
  assign sts_o.out_free = out_free;

  assign out_valid_o   = out_valid_q;
  assign match_count_o = out_count_q;
  assign truncated_o   = out_trunc_q;

  a_range_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !active_q && out_valid_q)
    else $error("final pattern word did not close the range");

  a_range_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pat_start |=> active_q)
    else $error("pattern word did not open the range");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result pushed over a pending word");

endmodule

// ===== rtl/bwt_backward_search_counter.sv =====
// FM-index backward search counter over the alphabet $,A,C,G,T: top level.
// A load word is taken in the idle state; one marked last adds a prefix-sum
// pass over ALPHABET_SIZE symbols that derives the first sorted positions. A
// pattern word first reads the top and bottom rows of the occurrence memory
// through its two read ports, then updates the match range. The range step of
// one pattern word needs the range left by the previous one. The occurrence
// memory holds one row of ALPHABET_SIZE counts per text position, MAX_LEN + 1
// rows; row zero is implied zero, so no clearing pass follows reset. A result
// word waits in an output register while new words are taken.
// Depends on bbs_pkg, bbs_ctrl and bbs_datapath.
module bwt_backward_search_counter #(
  parameter int unsigned MAX_LEN       = 4096,
  parameter int unsigned ALPHABET_SIZE = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic [bbs_pkg::SYM_W-1:0]   symbol_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bbs_pkg::MATCH_W-1:0] match_count_o,
  output logic                        truncated_o
);
  import bbs_pkg::*;

  bbs_cmd_t cmd;
  bbs_sts_t sts;

  bbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .last_i     (last_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bbs_datapath #(
    .MAX_LEN       (MAX_LEN),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .symbol_i      (symbol_i),
    .last_i        (last_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .match_count_o (match_count_o),
    .truncated_o   (truncated_o)
  );

endmodule

// ===== bench/bwt_backward_search_counter_tb.sv =====
// Testbench for bwt_backward_search_counter: loads transforms, runs backward
// searches and checks every match count word against an in-bench FM-index model.
// Depends on bbs_pkg and the bwt_backward_search_counter RTL.
module bwt_backward_search_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAXLEN = 4096;
  localparam int unsigned ALPHA  = 5;

  typedef enum logic {CMD_LOAD = 1'b0, CMD_PATTERN = 1'b1} cmd_e;
  typedef enum logic [2:0] {
    SYM_END = 3'd0, SYM_A = 3'd1, SYM_C = 3'd2, SYM_G = 3'd3, SYM_T = 3'd4,
    SYM_X5 = 3'd5, SYM_X6 = 3'd6, SYM_X7 = 3'd7
  } sym_e;

  typedef struct packed {
    logic [bbs_pkg::MATCH_W-1:0] count;
    logic                        trunc;
  } match_word_t;

  logic                        clk_i;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_ready_o;
  logic                        cmd_i         = 1'b0;
  logic [bbs_pkg::SYM_W-1:0]   symbol_i      = '0;
  logic                        last_i        = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i   = 1'b0;
  logic [bbs_pkg::MATCH_W-1:0] match_count_o;
  logic                        truncated_o;

  logic [12:0] occ_cnt [ALPHA][MAXLEN+1];
  logic [12:0] sym_total [ALPHA];
  logic [12:0] sym_base [ALPHA];
  logic [12:0] text_len;
  logic [12:0] rng_top;
  logic [12:0] rng_end;
  logic        in_pattern;
  logic        overflow;

  match_word_t match_q [$];
  int          err_cnt     = 0;
  int          words_sent  = 0;
  int          results_seen = 0;
  int          stall_left  = 0;
  bit          send_idle   = 1'b0;
  bit          recv_idle   = 1'b0;
  bit          load_noise  = 1'b0;

  bwt_backward_search_counter #(
    .MAX_LEN      (MAXLEN),
    .ALPHABET_SIZE(ALPHA)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .symbol_i     (symbol_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .match_count_o(match_count_o),
    .truncated_o  (truncated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void search_state_reset();
    int c;
    for (c = 0; c < ALPHA; c++) begin
      occ_cnt[c][0] = '0;
      sym_total[c]  = '0;
      sym_base[c]   = '0;
    end
    text_len   = '0;
    rng_top    = '0;
    rng_end    = '0;
    in_pattern = 1'b0;
    overflow   = 1'b0;
  endfunction

  function automatic void fm_search_step(logic c, logic [2:0] s, logic l);
    int          k;
    logic [12:0] sum;
    logic [12:0] nt;
    logic [12:0] ne;
    match_word_t w;
    if (c == CMD_LOAD) begin
      if (s < ALPHA) begin
        if (text_len >= MAXLEN) begin
          overflow = 1'b1;
        end else begin
          sym_total[s] = sym_total[s] + 1'b1;
          text_len     = text_len + 1'b1;
          for (k = 0; k < ALPHA; k++) occ_cnt[k][text_len] = sym_total[k];
        end
      end
      if (l) begin
        sum = '0;
        for (k = 0; k < ALPHA; k++) begin
          sym_base[k] = sum;
          sum         = sum + sym_total[k];
        end
      end
      return;
    end
    if (!in_pattern) begin
      rng_top    = '0;
      rng_end    = text_len;
      in_pattern = 1'b1;
    end
    if (s >= ALPHA) begin
      rng_top = '0;
      rng_end = '0;
    end else if (rng_top < rng_end && rng_end <= MAXLEN) begin
      nt      = sym_base[s] + occ_cnt[s][rng_top];
      ne      = sym_base[s] + occ_cnt[s][rng_end];
      rng_top = nt;
      rng_end = ne;
    end
    if (!l) return;
    w.count    = (rng_top < rng_end) ? (rng_end - rng_top) : '0;
    w.trunc    = overflow;
    in_pattern = 1'b0;
    match_q.push_back(w);
  endfunction

  function automatic logic [2:0] pick_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 3'($urandom_range(SYM_X5, SYM_X7));
    if (r < 16) return SYM_END;
    return 3'($urandom_range(SYM_A, SYM_T));
  endfunction

  task automatic send_word(logic c, logic [2:0] s, logic l);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    symbol_i   <= s;
    last_i     <= l;
    do @(posedge clk_i); while (!in_ready_o);
    fm_search_step(c, s, l);
    words_sent++;
  endtask

  task automatic send_pattern(int plen);
    int k;
    for (k = 0; k < plen; k++) begin
      if (load_noise && $urandom_range(0, 29) == 0) begin
        send_word(CMD_LOAD, pick_symbol(), 1'($urandom_range(0, 1)));
      end
      send_word(CMD_PATTERN, pick_symbol(), k == plen - 1);
    end
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (match_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : rx_check
    match_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (match_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual count %0d trunc %0b",
                 $time, match_count_o, truncated_o);
      end else begin
        exp_w = match_q.pop_front();
        if (match_count_o !== exp_w.count) begin
          err_cnt++;
          $display("%0t: match_count mismatch, expected %0d, actual %0d",
                   $time, exp_w.count, match_count_o);
        end
        if (truncated_o !== exp_w.trunc) begin
          err_cnt++;
          $display("%0t: truncated mismatch, expected %0b, actual %0b",
                   $time, exp_w.trunc, truncated_o);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic test_directed();
    send_word(CMD_PATTERN, SYM_T, 1'b1);
    send_word(CMD_PATTERN, SYM_X7, 1'b0);
    send_word(CMD_PATTERN, SYM_END, 1'b1);
    send_word(CMD_LOAD, SYM_A, 1'b0);
    send_word(CMD_LOAD, SYM_C, 1'b0);
    send_word(CMD_LOAD, SYM_X5, 1'b0);
    send_word(CMD_LOAD, SYM_G, 1'b0);
    send_word(CMD_LOAD, SYM_T, 1'b0);
    send_word(CMD_LOAD, SYM_G, 1'b0);
    send_word(CMD_LOAD, SYM_A, 1'b0);
    send_word(CMD_PATTERN, SYM_A, 1'b1);
    send_word(CMD_LOAD, SYM_END, 1'b1);
    send_word(CMD_PATTERN, SYM_G, 1'b1);
    send_word(CMD_PATTERN, SYM_T, 1'b0);
    send_word(CMD_PATTERN, SYM_G, 1'b1);
    send_word(CMD_PATTERN, SYM_X6, 1'b0);
    send_word(CMD_PATTERN, SYM_A, 1'b1);
    send_word(CMD_PATTERN, SYM_END, 1'b0);
    send_word(CMD_PATTERN, SYM_END, 1'b0);
    send_word(CMD_PATTERN, SYM_C, 1'b1);
    send_word(CMD_LOAD, SYM_X7, 1'b1);
    send_word(CMD_PATTERN, SYM_C, 1'b1);
  endtask

  task automatic test_random_search(int n_words);
    int k;
    int chunk;
    int n_pat;
    load_noise = 1'b1;
    while (words_sent < n_words) begin
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      if (text_len < 8 || $urandom_range(0, 2) == 0) begin
        chunk = $urandom_range(1, 16);
        for (k = 0; k < chunk; k++) begin
          send_word(CMD_LOAD, pick_symbol(), k == chunk - 1 && $urandom_range(0, 5) != 0);
        end
      end
      n_pat = $urandom_range(1, 6);
      for (k = 0; k < n_pat; k++) send_pattern($urandom_range(1, 4));
    end
    load_noise = 1'b0;
  endtask

  task automatic test_sender_pause();
    int k;
    send_idle = 1'b0;
    recv_idle = 1'b1;
    for (k = 0; k < 4; k++) send_pattern($urandom_range(1, 3));
    wait_results();
    for (k = 0; k < 4; k++) send_pattern($urandom_range(1, 3));
  endtask

  task automatic test_overflow();
    int k;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    while (text_len < MAXLEN) begin
      send_word(CMD_LOAD, 3'($urandom_range(SYM_END, SYM_T)), 1'b0);
    end
    for (k = 0; k < 5; k++) send_word(CMD_LOAD, 3'($urandom_range(SYM_END, SYM_T)), 1'b0);
    send_word(CMD_LOAD, SYM_X7, 1'b1);
    for (k = 0; k < 30; k++) send_pattern($urandom_range(1, 4));
  endtask

  initial begin
    search_state_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_search(600);
    test_sender_pause();
    test_random_search(1150);
    test_overflow();
    wait_results();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d words, checked %0d match results; text grew to %0d symbols%s.",
             words_sent, results_seen, text_len, overflow ? " past capacity" : "");
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
